/* rtl/spqc_pkg.sv */
// Shared types and constants for the sprite quad clip and UV core.
// Used by spqc_div and sprite_quad_clip_uv_core; depends on nothing else.
package spqc_pkg;

    localparam int UV_FRAC_BITS = 15;
    localparam logic [15:0] UV_ONE = 16'(1 << UV_FRAC_BITS);

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 48;
    localparam int DIV_Q_W   = 16;

    localparam logic [2:0] REG_NEAR_CLIP   = 3'd0;
    localparam logic [2:0] REG_FAR_CLIP    = 3'd1;
    localparam logic [2:0] REG_NEAR_SCREEN = 3'd2;
    localparam logic [2:0] REG_FAR_SCREEN  = 3'd3;
    localparam logic [2:0] REG_SCR_WIDTH   = 3'd4;
    localparam logic [2:0] REG_SCR_HEIGHT  = 3'd5;

    typedef enum logic [1:0] {
        CLIP_NONE = 2'd0,
        CLIP_LOW  = 2'd1,
        CLIP_HIGH = 2'd2
    } clip_t;

    typedef struct packed {
        logic [23:0]      z;
        logic [31:0]      rd;
        logic [7:0]       al;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        logic             zero;
        logic             down;
        logic [15:0]      ns;
        clip_t [3:0]      mode;
        logic [3:0][15:0] pos;
        logic             hw_zero;
        logic             hh_zero;
    } side_t;

endpackage

/* rtl/spqc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on spqc_pkg for its fixed widths.
module spqc_div
    import spqc_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_Q_W-1:0]   quo,
    output logic                 ovf
);

    localparam int CW = DIV_NUM_W + 1;

    logic [DIV_NUM_W-1:0] rem_reg [0:DIV_Q_W];
    logic [DIV_DEN_W-1:0] den_reg [0:DIV_Q_W];
    logic [DIV_Q_W-1:0]   q_reg   [0:DIV_Q_W];
    logic                 ovf_reg [0:DIV_Q_W];

    logic [DIV_NUM_W-1:0] rem_next [0:DIV_Q_W-1];
    logic [DIV_Q_W-1:0]   q_next   [0:DIV_Q_W-1];
    logic [CW-1:0]        top_cmp;

    assign top_cmp = CW'(den) << DIV_Q_W;

    always_comb
    begin
        for (int s = 0; s < DIV_Q_W; s++)
        begin
            logic [CW-1:0] trial;
            trial = CW'(den_reg[s]) << (DIV_Q_W - 1 - s);
            if (CW'(rem_reg[s]) >= trial)
            begin
                rem_next[s] = rem_reg[s] - trial[DIV_NUM_W-1:0];
                q_next[s]   = q_reg[s] | (DIV_Q_W'(1) << (DIV_Q_W - 1 - s));
            end
            else
            begin
                rem_next[s] = rem_reg[s];
                q_next[s]   = q_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (CW'(num) >= top_cmp);
            for (int s = 0; s < DIV_Q_W; s++)
            begin
                rem_reg[s+1] <= rem_next[s];
                den_reg[s+1] <= den_reg[s];
                q_reg[s+1]   <= q_next[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    assign quo = q_reg[DIV_Q_W];
    assign ovf = ovf_reg[DIV_Q_W];

endmodule

/* rtl/sprite_quad_clip_uv_core.sv */
// Sprite quad clipping with UV adjust: four clamped corner vertices per sprite word.
// Depends on spqc_pkg and instantiates five spqc_div pipelines.
// An accepted input word passes stages A to D, the divider pipelines and the output
// buffer before its first vertex is output. The sprite rate is set by the four vertex
// words per sprite on the output; the dividers accept a sprite in every unstalled cycle.
// Reset clears all valid bits and the vertex counter and loads the register defaults.
module sprite_quad_clip_uv_core
    import spqc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // centre_x, centre_y, depth, half_width, half_height, red, green, blue,
    // intensity, recip_depth, alpha
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vertex_x, vertex_y, screen_depth, camera_depth, recip_out, out_red,
    // out_green, out_blue, out_alpha, tex_u, tex_v
    output logic [167:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    localparam int DLY = DIV_Q_W + 1;

    logic [23:0] near_reg, far_reg;
    logic [15:0] ns_reg, fs_reg, sw_reg, sh_reg;

    logic adv, last_valid, buf_free;

    // Stage A
    logic              a_valid_reg;
    logic signed [19:0] a_cx_reg, a_cy_reg;
    logic [23:0] a_z_reg;
    logic [18:0] a_hw_reg, a_hh_reg;
    logic [7:0]  a_r_reg, a_g_reg, a_b_reg, a_al_reg;
    logic [8:0]  a_k_reg;
    logic [31:0] a_rd_reg;

    // Stage B
    logic              b_valid_reg;
    logic signed [20:0] b_px_reg [0:3];
    logic [23:0] b_zn_reg, b_z_reg;
    logic [39:0] b_sf_reg;
    logic [47:0] b_den_reg;
    logic        b_zero_reg, b_down_reg;
    logic [7:0]  b_r_reg, b_g_reg, b_b_reg, b_al_reg;
    logic [31:0] b_rd_reg;
    logic [18:0] b_hw_reg, b_hh_reg;

    // Stage C
    logic        c_valid_reg;
    logic [43:0] c_hi_reg, c_lo_reg;
    logic [47:0] c_den_reg;
    logic [20:0] c_d_reg [0:3];
    logic [18:0] c_hw_reg, c_hh_reg;
    side_t       c_side_reg;

    // Stage D
    logic        d_valid_reg;
    logic [63:0] d_num_reg;
    logic [47:0] d_den_reg;
    logic [20:0] d_d_reg [0:3];
    logic [18:0] d_hw_reg, d_hh_reg;
    side_t       d_side_reg;

    logic  sv_reg   [0:DLY-1];
    side_t side_reg [0:DLY-1];

    logic [15:0] dq   [0:4];
    logic        dovf [0:4];

    // Output buffer
    logic        buf_valid_reg;
    logic [1:0]  cnt_reg;
    logic [15:0] bx_reg [0:1];
    logic [15:0] by_reg [0:1];
    logic [15:0] bu_reg [0:1];
    logic [15:0] bv_reg [0:1];
    logic [15:0] bsd_reg;
    side_t       bside_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= 24'd256;
            far_reg  <= 24'd512000;
            ns_reg   <= 16'd0;
            fs_reg   <= 16'd65535;
            sw_reg   <= 16'd10240;
            sh_reg   <= 16'd7680;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_NEAR_CLIP:   near_reg <= cfg_data;
                REG_FAR_CLIP:    far_reg  <= cfg_data;
                REG_NEAR_SCREEN: ns_reg   <= cfg_data[15:0];
                REG_FAR_SCREEN:  fs_reg   <= cfg_data[15:0];
                REG_SCR_WIDTH:   sw_reg   <= cfg_data[15:0];
                REG_SCR_HEIGHT:  sh_reg   <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    assign last_valid = sv_reg[DLY-1];
    assign buf_free   = !buf_valid_reg || (m_tready && cnt_reg == 2'd3);
    assign adv        = !last_valid || buf_free;
    assign s_tready   = adv;

    // Stage B logic
    logic        b_down_next;
    logic [15:0] b_span;
    logic [16:0] prod_r, prod_g, prod_b;

    assign b_down_next = fs_reg < ns_reg;
    assign b_span      = b_down_next ? ns_reg - fs_reg : fs_reg - ns_reg;
    assign prod_r      = 17'(a_r_reg) * 17'(a_k_reg);
    assign prod_g      = 17'(a_g_reg) * 17'(a_k_reg);
    assign prod_b      = 17'(a_b_reg) * 17'(a_k_reg);

    function automatic logic [7:0] sat8(input logic [16:0] p);
        return (p[16]) ? 8'hFF : p[15:8];
    endfunction

    // Stage C logic: clip decisions per corner axis (x minus, x plus, y minus, y plus)
    clip_t       c_mode_next [0:3];
    logic [15:0] c_pos_next  [0:3];
    logic [20:0] c_d_next    [0:3];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic [15:0] lim;
            lim = (i < 2) ? sw_reg : sh_reg;
            if (b_px_reg[i] < 0)
            begin
                c_mode_next[i] = CLIP_LOW;
                c_pos_next[i]  = '0;
                c_d_next[i]    = 21'(-b_px_reg[i]);
            end
            else if (b_px_reg[i] > $signed({5'd0, lim}))
            begin
                c_mode_next[i] = CLIP_HIGH;
                c_pos_next[i]  = lim;
                c_d_next[i]    = 21'(b_px_reg[i] - $signed({5'd0, lim}));
            end
            else
            begin
                c_mode_next[i] = CLIP_NONE;
                c_pos_next[i]  = b_px_reg[i][15:0];
                c_d_next[i]    = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_cx_reg <= $signed(s_tdata[19:0]);
            a_cy_reg <= $signed(s_tdata[39:20]);
            a_z_reg  <= s_tdata[63:40];
            a_hw_reg <= s_tdata[82:64];
            a_hh_reg <= s_tdata[101:83];
            a_r_reg  <= s_tdata[109:102];
            a_g_reg  <= s_tdata[117:110];
            a_b_reg  <= s_tdata[125:118];
            a_k_reg  <= s_tdata[134:126];
            a_rd_reg <= s_tdata[166:135];
            a_al_reg <= s_tdata[174:167];

            b_px_reg[0] <= 21'(a_cx_reg) - $signed({2'b0, a_hw_reg});
            b_px_reg[1] <= 21'(a_cx_reg) + $signed({2'b0, a_hw_reg});
            b_px_reg[2] <= 21'(a_cy_reg) - $signed({2'b0, a_hh_reg});
            b_px_reg[3] <= 21'(a_cy_reg) + $signed({2'b0, a_hh_reg});
            b_zn_reg   <= a_z_reg - near_reg;
            b_sf_reg   <= 40'(b_span) * 40'(far_reg);
            b_den_reg  <= 48'(far_reg - near_reg) * 48'(a_z_reg);
            b_zero_reg <= (a_z_reg <= near_reg) || (far_reg <= near_reg);
            b_down_reg <= b_down_next;
            b_r_reg    <= sat8(prod_r);
            b_g_reg    <= sat8(prod_g);
            b_b_reg    <= sat8(prod_b);
            b_z_reg    <= a_z_reg;
            b_rd_reg   <= a_rd_reg;
            b_al_reg   <= a_al_reg;
            b_hw_reg   <= a_hw_reg;
            b_hh_reg   <= a_hh_reg;

            c_hi_reg  <= 44'(b_zn_reg) * 44'(b_sf_reg[39:20]);
            c_lo_reg  <= 44'(b_zn_reg) * 44'(b_sf_reg[19:0]);
            c_den_reg <= b_den_reg;
            c_hw_reg  <= b_hw_reg;
            c_hh_reg  <= b_hh_reg;
            for (int i = 0; i < 4; i++)
            begin
                c_d_reg[i]         <= c_d_next[i];
                c_side_reg.mode[i] <= c_mode_next[i];
                c_side_reg.pos[i]  <= c_pos_next[i];
            end
            c_side_reg.z       <= b_z_reg;
            c_side_reg.rd      <= b_rd_reg;
            c_side_reg.al      <= b_al_reg;
            c_side_reg.r       <= b_r_reg;
            c_side_reg.g       <= b_g_reg;
            c_side_reg.b       <= b_b_reg;
            c_side_reg.zero    <= b_zero_reg;
            c_side_reg.down    <= b_down_reg;
            c_side_reg.ns      <= ns_reg;
            c_side_reg.hw_zero <= (b_hw_reg == '0);
            c_side_reg.hh_zero <= (b_hh_reg == '0);

            d_num_reg  <= (64'(c_hi_reg) << 20) + 64'(c_lo_reg);
            d_den_reg  <= c_den_reg;
            d_hw_reg   <= c_hw_reg;
            d_hh_reg   <= c_hh_reg;
            d_side_reg <= c_side_reg;
            for (int i = 0; i < 4; i++)
            begin
                d_d_reg[i] <= c_d_reg[i];
            end

            side_reg[0] <= d_side_reg;
            for (int s = 1; s < DLY; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            for (int s = 0; s < DLY; s++)
            begin
                sv_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            sv_reg[0]   <= d_valid_reg;
            for (int s = 1; s < DLY; s++)
            begin
                sv_reg[s] <= sv_reg[s-1];
            end
        end
    end

    spqc_div u_div_z (
        .clk (clk),
        .en  (adv),
        .num (d_num_reg),
        .den (d_den_reg),
        .quo (dq[4]),
        .ovf (dovf[4])
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_uv
        spqc_div u_div_uv (
            .clk (clk),
            .en  (adv),
            .num (DIV_NUM_W'(d_d_reg[i]) << (UV_FRAC_BITS - 1)),
            .den (DIV_DEN_W'((i < 2) ? d_hw_reg : d_hh_reg)),
            .quo (dq[i]),
            .ovf (dovf[i])
        );
    end

    // Final results from the divider outputs
    side_t       ls;
    logic [15:0] fin_tc [0:3];
    logic [15:0] fin_sd;
    logic [16:0] sd_sum;

    assign ls     = side_reg[DLY-1];
    assign sd_sum = 17'(ls.ns) + 17'(dq[4]);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            case (ls.mode[i])
                CLIP_LOW:
                    fin_tc[i] = (dovf[i] || dq[i] > UV_ONE) ? UV_ONE : dq[i];
                CLIP_HIGH:
                    fin_tc[i] = (dovf[i] || dq[i] >= UV_ONE) ? 16'd0 : UV_ONE - dq[i];
                default:
                    fin_tc[i] = i[0] ? UV_ONE : 16'd0;
            endcase
            if ((i < 2) ? ls.hw_zero : ls.hh_zero)
            begin
                fin_tc[i] = '0;
            end
        end
        if (ls.zero)
        begin
            fin_sd = '0;
        end
        else if (ls.down)
        begin
            fin_sd = (dovf[4] || dq[4] >= ls.ns) ? 16'd0 : ls.ns - dq[4];
        end
        else
        begin
            fin_sd = (dovf[4] || sd_sum[16]) ? 16'hFFFF : sd_sum[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && last_valid)
        begin
            bx_reg[0] <= ls.pos[0];
            bx_reg[1] <= ls.pos[1];
            by_reg[0] <= ls.pos[2];
            by_reg[1] <= ls.pos[3];
            bu_reg[0] <= fin_tc[0];
            bu_reg[1] <= fin_tc[1];
            bv_reg[0] <= fin_tc[2];
            bv_reg[1] <= fin_tc[3];
            bsd_reg   <= fin_sd;
            bside_reg <= ls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (adv && last_valid)
        begin
            buf_valid_reg <= 1'b1;
            cnt_reg       <= '0;
        end
        else if (buf_valid_reg && m_tready)
        begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                buf_valid_reg <= 1'b0;
            end
        end
    end

    logic xsel, ysel;
    assign xsel = cnt_reg[1];
    assign ysel = cnt_reg[1] ^ cnt_reg[0];

    assign m_tvalid = buf_valid_reg;
    assign m_tlast  = (cnt_reg == 2'd3);
    assign m_tdata  = {bv_reg[ysel], bu_reg[xsel], bside_reg.al, bside_reg.b,
                       bside_reg.g, bside_reg.r, bside_reg.rd, bside_reg.z,
                       bsd_reg, by_reg[ysel], bx_reg[xsel]};

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (last_valid && !adv) |-> buf_valid_reg)
        else $error("Pipeline stalled with an empty output buffer.");

    a_hold_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(cnt_reg)))
        else $error("Vertex counter moved while the output word was stalled.");

    a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[151:136] <= UV_ONE && m_tdata[167:152] <= UV_ONE))
        else $error("Texture coordinate above one.");

endmodule
